[src/bengali_text_normalizer_macros.svh]
// Assertion helpers shared by the normalizer modules.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef BENGALI_TEXT_NORMALIZER_MACROS_SVH
`define BENGALI_TEXT_NORMALIZER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BNORM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BNORM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/bnorm_pkg.sv]
`default_nettype none

package bnorm_pkg;

  localparam int CHAR_W              = 16;
  localparam int DEF_MAX_TOKEN_CHARS = 32;

  localparam logic [CHAR_W-1:0] CH_CANDRABINDU = 16'h0981;
  localparam logic [CHAR_W-1:0] CH_ANUSVARA    = 16'h0982;
  localparam logic [CHAR_W-1:0] CH_VISARGA     = 16'h0983;
  localparam logic [CHAR_W-1:0] CH_KA          = 16'h0995;
  localparam logic [CHAR_W-1:0] CH_KHA         = 16'h0996;
  localparam logic [CHAR_W-1:0] CH_NGA         = 16'h0999;
  localparam logic [CHAR_W-1:0] CH_NNA         = 16'h09A3;
  localparam logic [CHAR_W-1:0] CH_TA          = 16'h09A4;
  localparam logic [CHAR_W-1:0] CH_NA          = 16'h09A8;
  localparam logic [CHAR_W-1:0] CH_BA          = 16'h09AC;
  localparam logic [CHAR_W-1:0] CH_YA          = 16'h09AF;
  localparam logic [CHAR_W-1:0] CH_RA          = 16'h09B0;
  localparam logic [CHAR_W-1:0] CH_SHA         = 16'h09B6;
  localparam logic [CHAR_W-1:0] CH_SSA         = 16'h09B7;
  localparam logic [CHAR_W-1:0] CH_SA          = 16'h09B8;
  localparam logic [CHAR_W-1:0] CH_HA          = 16'h09B9;
  localparam logic [CHAR_W-1:0] CH_AA_SIGN     = 16'h09BE;
  localparam logic [CHAR_W-1:0] CH_I_SIGN      = 16'h09BF;
  localparam logic [CHAR_W-1:0] CH_II_SIGN     = 16'h09C0;
  localparam logic [CHAR_W-1:0] CH_U_SIGN      = 16'h09C1;
  localparam logic [CHAR_W-1:0] CH_UU_SIGN     = 16'h09C2;
  localparam logic [CHAR_W-1:0] CH_E_SIGN      = 16'h09C7;
  localparam logic [CHAR_W-1:0] CH_VIRAMA      = 16'h09CD;
  localparam logic [CHAR_W-1:0] CH_KHANDA_TA   = 16'h09CE;
  localparam logic [CHAR_W-1:0] CH_RRA         = 16'h09DC;
  localparam logic [CHAR_W-1:0] CH_RHA         = 16'h09DD;

  // What one scan step does to the top of the left stack.
  typedef enum logic [1:0] {
    LOP_KEEP,
    LOP_PUSH,
    LOP_POP,
    LOP_SET
  } lop_e;

  // Characters around the scan point plus the position tests the rules need.
  typedef struct packed {
    logic [CHAR_W-1:0] c;
    logic [CHAR_W-1:0] n1;
    logic [CHAR_W-1:0] n2;
    logic [CHAR_W-1:0] p1;
    logic [CHAR_W-1:0] p2;
    logic [CHAR_W-1:0] p3;
    logic              lcnt_zero;
    logic              lcnt_eq2;
    logic              lcnt_ge2;
    logic              lcnt_ge5;
    logic              rcnt_eq1;
    logic              rcnt_gt1;
    logic              rcnt_gt2;
    logic              len_le3;
  } window_t;

  typedef struct packed {
    lop_e              l_op;
    logic [CHAR_W-1:0] l_val;
    logic [1:0]        r_shift;
    logic              r_set;
    logic [CHAR_W-1:0] r_val;
  } rule_t;

  typedef struct packed {
    logic load_push;
    logic set_ovf;
    logic unwind;
    logic scan;
    logic emit_pop;
    logic clear_ovf;
  } cmd_t;

  typedef struct packed {
    logic lcnt_zero;
    logic rcnt_zero;
    logic rcnt_le1;
    logic full;
  } status_t;

endpackage

`default_nettype wire

[src/bnorm_rules.sv]
`default_nettype none

module bnorm_rules (
  input  bnorm_pkg::window_t win_i,
  output bnorm_pkg::rule_t   rule_o
);
  import bnorm_pkg::*;

  // The scan point sits between the stacks: c is the character under the scan index,
  // n1 and n2 follow it, p1..p3 precede it. Plain advance pushes c to the left stack.
  always_comb begin
    rule_o.l_op    = LOP_PUSH;
    rule_o.l_val   = win_i.c;
    rule_o.r_shift = 2'd1;
    rule_o.r_set   = 1'b0;
    rule_o.r_val   = CH_KHA;
    unique case (win_i.c)
      CH_CANDRABINDU: begin
        rule_o.l_op = LOP_KEEP;
      end
      CH_II_SIGN: rule_o.l_val = CH_I_SIGN;
      CH_UU_SIGN: rule_o.l_val = CH_U_SIGN;
      CH_KA: begin
        if (win_i.rcnt_gt2 && win_i.n1 == CH_VIRAMA && win_i.n2 == CH_I_SIGN) begin
          if (win_i.lcnt_zero) begin
            rule_o.l_val   = CH_KHA;
            rule_o.r_shift = 2'd3;
          end else begin
            // Virama becomes kha and the vowel sign goes away.
            rule_o.r_shift = 2'd2;
            rule_o.r_set   = 1'b1;
          end
        end
      end
      CH_NGA: rule_o.l_val = CH_ANUSVARA;
      CH_YA: begin
        if (win_i.lcnt_eq2 && win_i.p1 == CH_VIRAMA) begin
          rule_o.l_op  = LOP_SET;
          rule_o.l_val = CH_E_SIGN;
          if (win_i.rcnt_gt1 && win_i.n1 == CH_AA_SIGN) begin
            rule_o.r_shift = 2'd2;
          end
        end else if (!win_i.lcnt_zero && win_i.p1 == CH_VIRAMA) begin
          rule_o.l_op = LOP_POP;
        end
      end
      CH_BA: begin
        if (!win_i.lcnt_zero && win_i.p1 == CH_VIRAMA) begin
          if (win_i.lcnt_eq2 || (win_i.lcnt_ge5 && win_i.p3 == CH_VIRAMA)) begin
            rule_o.l_op = LOP_POP;
          end else if (win_i.lcnt_ge2) begin
            // Doubles the consonant before the virama and drops the ba.
            rule_o.l_op  = LOP_SET;
            rule_o.l_val = win_i.p2;
          end
        end
      end
      CH_VISARGA: begin
        if (win_i.rcnt_eq1) begin
          if (win_i.len_le3) begin
            rule_o.l_val = CH_HA;
          end else begin
            rule_o.l_op = LOP_KEEP;
          end
        end else begin
          rule_o.l_val = win_i.n1;
        end
      end
      CH_SHA, CH_SSA:   rule_o.l_val = CH_SA;
      CH_NNA:           rule_o.l_val = CH_NA;
      CH_RRA, CH_RHA:   rule_o.l_val = CH_RA;
      CH_KHANDA_TA:     rule_o.l_val = CH_TA;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[src/bnorm_dp.sv]
`default_nettype none

`include "bengali_text_normalizer_macros.svh"

module bnorm_dp #(
  parameter int MAX_TOKEN_CHARS = bnorm_pkg::DEF_MAX_TOKEN_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bnorm_pkg::cmd_t               cmd_i,
  input  logic [bnorm_pkg::CHAR_W-1:0]  in_char_i,
  output bnorm_pkg::status_t            status_o,
  output logic [bnorm_pkg::CHAR_W-1:0]  out_char_o,
  output logic                          out_last_o,
  output logic                          out_empty_o,
  output logic                          out_overflow_o
);
  import bnorm_pkg::*;

  localparam int CNT_W = $clog2(MAX_TOKEN_CHARS + 1);

  // The token lives in two stacks that meet at the scan point. The left stack holds
  // the characters before it (top = nearest), the right stack those from it on.
  logic [MAX_TOKEN_CHARS-1:0][CHAR_W-1:0] l_q, l_d;
  logic [MAX_TOKEN_CHARS-1:0][CHAR_W-1:0] r_q, r_d;
  logic [CNT_W-1:0] lcnt_q, lcnt_d;
  logic [CNT_W-1:0] rcnt_q, rcnt_d;
  logic             ovf_q, ovf_d;
  logic [CNT_W:0]   total;

  window_t win;
  rule_t   rule;

  logic              l_push, l_pop, l_set;
  logic [CHAR_W-1:0] l_val;
  logic              r_push, r_set;
  logic [1:0]        r_shift;
  logic [CHAR_W-1:0] r_val;

  assign total = {1'b0, lcnt_q} + {1'b0, rcnt_q};

  always_comb begin
    win.c         = r_q[0];
    win.n1        = r_q[1];
    win.n2        = r_q[2];
    win.p1        = l_q[0];
    win.p2        = l_q[1];
    win.p3        = l_q[2];
    win.lcnt_zero = (lcnt_q == '0);
    win.lcnt_eq2  = (lcnt_q == CNT_W'(2));
    win.lcnt_ge2  = (lcnt_q >= CNT_W'(2));
    win.lcnt_ge5  = (lcnt_q >= CNT_W'(5));
    win.rcnt_eq1  = (rcnt_q == CNT_W'(1));
    win.rcnt_gt1  = (rcnt_q > CNT_W'(1));
    win.rcnt_gt2  = (rcnt_q > CNT_W'(2));
    win.len_le3   = (total <= (CNT_W+1)'(3));
  end

  bnorm_rules u_rules (
    .win_i  (win),
    .rule_o (rule)
  );

  always_comb begin
    l_push  = 1'b0;
    l_pop   = 1'b0;
    l_set   = 1'b0;
    l_val   = in_char_i;
    r_push  = 1'b0;
    r_set   = 1'b0;
    r_shift = 2'd0;
    r_val   = rule.r_val;
    if (cmd_i.load_push) begin
      l_push = 1'b1;
    end
    if (cmd_i.unwind) begin
      l_pop  = 1'b1;
      r_push = 1'b1;
    end
    if (cmd_i.scan) begin
      l_val   = rule.l_val;
      r_shift = rule.r_shift;
      r_set   = rule.r_set;
      unique case (rule.l_op)
        LOP_KEEP: begin
        end
        LOP_PUSH: l_push = 1'b1;
        LOP_POP:  l_pop  = 1'b1;
        LOP_SET:  l_set  = 1'b1;
      endcase
    end
    if (cmd_i.emit_pop) begin
      r_shift = 2'd1;
    end

    l_d = l_q;
    if (l_push) begin
      l_d = {l_q[MAX_TOKEN_CHARS-2:0], l_val};
    end else if (l_pop) begin
      l_d = l_q >> CHAR_W;
    end else if (l_set) begin
      l_d[0] = l_val;
    end

    if (r_push) begin
      r_d = {r_q[MAX_TOKEN_CHARS-2:0], l_q[0]};
    end else begin
      unique case (r_shift)
        2'd0: r_d = r_q;
        2'd1: r_d = r_q >> CHAR_W;
        2'd2: r_d = r_q >> (2 * CHAR_W);
        2'd3: r_d = r_q >> (3 * CHAR_W);
      endcase
    end
    if (r_set) begin
      r_d[0] = r_val;
    end

    lcnt_d = lcnt_q + CNT_W'(l_push) - CNT_W'(l_pop);
    rcnt_d = rcnt_q + CNT_W'(r_push) - CNT_W'(r_shift);

    ovf_d = ovf_q;
    if (cmd_i.set_ovf) begin
      ovf_d = 1'b1;
    end else if (cmd_i.clear_ovf) begin
      ovf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcnt_q <= '0;
      rcnt_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      lcnt_q <= lcnt_d;
      rcnt_q <= rcnt_d;
      ovf_q  <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    l_q <= l_d;
    r_q <= r_d;
  end

  assign status_o.lcnt_zero = (lcnt_q == '0);
  assign status_o.rcnt_zero = (rcnt_q == '0);
  assign status_o.rcnt_le1  = (rcnt_q <= CNT_W'(1));
  assign status_o.full      = (lcnt_q == CNT_W'(MAX_TOKEN_CHARS));

  assign out_char_o     = (rcnt_q == '0) ? '0 : r_q[0];
  assign out_last_o     = (rcnt_q <= CNT_W'(1));
  assign out_empty_o    = (rcnt_q == '0);
  assign out_overflow_o = ovf_q;

  `BNORM_ASSERT_IMP(a_dp_total_bounded, 1'b1, total <= (CNT_W+1)'(MAX_TOKEN_CHARS),
                    "both stacks together hold more than the buffer depth")
  `BNORM_ASSERT_NXT(a_dp_scan_never_grows, cmd_i.scan, total <= $past(total),
                    "a rewrite step made the token longer")

endmodule

`default_nettype wire

[src/bnorm_ctrl.sv]
`default_nettype none

`include "bengali_text_normalizer_macros.svh"

module bnorm_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_last_i,
  input  logic               out_stall_i,
  input  bnorm_pkg::status_t status_i,
  output bnorm_pkg::cmd_t    cmd_o,
  output logic               in_stall_o,
  output logic               out_valid_o
);
  import bnorm_pkg::*;

  typedef enum logic [4:0] {
    ST_LOAD   = 5'b00001,
    ST_UNWIND = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_REWIND = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_LOAD: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (status_i.full) begin
            cmd_o.set_ovf = 1'b1;
          end else begin
            cmd_o.load_push = 1'b1;
          end
          if (in_last_i) begin
            state_d = ST_UNWIND;
          end
        end
      end
      // Loading stacks the token backwards; moving it across restores reading order.
      ST_UNWIND: begin
        if (status_i.lcnt_zero) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.unwind = 1'b1;
        end
      end
      ST_SCAN: begin
        if (status_i.rcnt_zero) begin
          state_d = ST_REWIND;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_REWIND: begin
        if (status_i.lcnt_zero) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.unwind = 1'b1;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (!status_i.rcnt_zero) begin
            cmd_o.emit_pop = 1'b1;
          end
          if (status_i.rcnt_le1) begin
            cmd_o.clear_ovf = 1'b1;
            state_d         = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  `BNORM_ASSERT_IMP(a_ctrl_load_right_empty, state_q == ST_LOAD, status_i.rcnt_zero,
                    "right stack holds characters while loading")
  `BNORM_ASSERT_NXT(a_ctrl_last_transfer_ends,
                    state_q == ST_EMIT && !out_stall_i && status_i.rcnt_le1,
                    state_q == ST_LOAD && status_i.lcnt_zero && status_i.rcnt_zero,
                    "token not fully drained after its last transfer")
  `BNORM_ASSERT_NXT(a_ctrl_unwind_to_scan, state_q == ST_UNWIND && status_i.lcnt_zero,
                    state_q == ST_SCAN,
                    "scan did not start once the token was in reading order")

endmodule

`default_nettype wire

[src/bengali_text_normalizer.sv]
// A token is loaded one transfer at a time, moved across the stacks to put it in reading
// order, rewritten by a scan (one rule per cycle), moved back, then sent out one character
// per output transfer. One token is processed at a time, and the next is accepted after
// its last output transfer.
// Asynchronous active-low reset empties the buffer, clears overflow and returns to loading.
`default_nettype none

module bengali_text_normalizer #(
  parameter int MAX_TOKEN_CHARS = bnorm_pkg::DEF_MAX_TOKEN_CHARS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [bnorm_pkg::CHAR_W-1:0] in_char_i,
  input  logic                         in_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [bnorm_pkg::CHAR_W-1:0] out_char_o,
  output logic                         out_last_o,
  output logic                         out_empty_o,
  output logic                         out_overflow_o
);
  import bnorm_pkg::*;

  cmd_t    cmd;
  status_t status;

  bnorm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_last_i),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  bnorm_dp #(
    .MAX_TOKEN_CHARS (MAX_TOKEN_CHARS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_char_i      (in_char_i),
    .status_o       (status),
    .out_char_o     (out_char_o),
    .out_last_o     (out_last_o),
    .out_empty_o    (out_empty_o),
    .out_overflow_o (out_overflow_o)
  );

endmodule

`default_nettype wire

[verif/testbench.sv]
`default_nettype none

module testbench;
  import bnorm_pkg::*;

  localparam int TOKEN_DEPTH   = DEF_MAX_TOKEN_CHARS;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_CHARS  = 12;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
    logic              empty;
    logic              ovf;
  } norm_res_t;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              in_valid_i     = 1'b0;
  logic [CHAR_W-1:0] in_char_i      = '0;
  logic              in_last_i      = 1'b0;
  logic              out_stall_i    = 1'b0;
  logic              in_stall_o;
  logic              out_valid_o;
  logic [CHAR_W-1:0] out_char_o;
  logic              out_last_o;
  logic              out_empty_o;
  logic              out_overflow_o;

  bengali_text_normalizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_char_i     (in_char_i),
    .in_last_i     (in_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_char_o    (out_char_o),
    .out_last_o    (out_last_o),
    .out_empty_o   (out_empty_o),
    .out_overflow_o(out_overflow_o)
  );

  always #10 clk_i = ~clk_i;

  // Predictor copy of the token being collected.
  logic [CHAR_W-1:0] tok_chars [TOKEN_DEPTH];
  int                tok_len = 0;
  bit                tok_ovf = 1'b0;
  norm_res_t         norm_due_q [$];
  norm_res_t         due_head;
  int                error_count = 0;

  logic [CHAR_W-1:0] stim_q [$];
  bit                tx_bursty  = 1'b0;
  int                burst_left = 0;
  int                gap_len    = 0;

  rx_mode_e rx_mode       = RX_OPEN;
  int       hold_requests = 0;
  int       hold_served   = 0;
  int       hold_left     = 0;
  int       rx_cycle      = 0;

  function automatic void drop_char(input int pos);
    if (pos >= 0 && pos < tok_len) begin
      for (int k = pos; k < tok_len - 1; k++) tok_chars[k] = tok_chars[k + 1];
      tok_len--;
    end
  endfunction

  // In-place rewrite scan; after deletions the index steps back so that the
  // shifted-in characters are examined again.
  function automatic void rewrite_token();
    int i;
    int pos;
    pos = 0;
    while (pos < tok_len) begin
      i = pos;
      case (tok_chars[i])
        CH_CANDRABINDU: begin
          drop_char(i);
          i--;
        end
        CH_II_SIGN: tok_chars[i] = CH_I_SIGN;
        CH_UU_SIGN: tok_chars[i] = CH_U_SIGN;
        CH_KA: begin
          if (i + 2 < tok_len && tok_chars[i + 1] == CH_VIRAMA &&
              tok_chars[i + 2] == CH_I_SIGN) begin
            if (i == 0) begin
              tok_chars[i] = CH_KHA;
              drop_char(i + 2);
              drop_char(i + 1);
            end else begin
              tok_chars[i + 1] = CH_KHA;
              drop_char(i + 2);
            end
          end
        end
        CH_NGA: tok_chars[i] = CH_ANUSVARA;
        CH_YA: begin
          if (i == 2 && tok_chars[1] == CH_VIRAMA) begin
            tok_chars[1] = CH_E_SIGN;
            if (i + 1 < tok_len && tok_chars[i + 1] == CH_AA_SIGN) drop_char(i + 1);
            drop_char(i);
            i--;
          end else if (i >= 1 && tok_chars[i - 1] == CH_VIRAMA) begin
            drop_char(i);
            drop_char(i - 1);
            i -= 2;
          end
        end
        CH_BA: begin
          if (i != 0 && tok_chars[i - 1] == CH_VIRAMA) begin
            if (i == 2 || (i >= 5 && tok_chars[i - 3] == CH_VIRAMA)) begin
              drop_char(i);
              drop_char(i - 1);
              i -= 2;
            end else if (i >= 2) begin
              tok_chars[i - 1] = tok_chars[i - 2];
              drop_char(i);
              i--;
            end
          end
        end
        CH_VISARGA: begin
          if (i == tok_len - 1) begin
            if (tok_len <= 3) tok_chars[i] = CH_HA;
            else drop_char(i);
          end else begin
            tok_chars[i] = tok_chars[i + 1];
          end
        end
        CH_SHA, CH_SSA: tok_chars[i] = CH_SA;
        CH_NNA: tok_chars[i] = CH_NA;
        CH_RRA, CH_RHA: tok_chars[i] = CH_RA;
        CH_KHANDA_TA: tok_chars[i] = CH_TA;
        default: ;
      endcase
      pos = i + 1;
    end
  endfunction

  function automatic void capture_char(input logic [CHAR_W-1:0] ch, input bit last);
    norm_res_t r;
    if (tok_len < TOKEN_DEPTH) begin
      tok_chars[tok_len] = ch;
      tok_len++;
    end else begin
      tok_ovf = 1'b1;
    end
    if (last) begin
      rewrite_token();
      if (tok_len == 0) begin
        r = '{ch: '0, last: 1'b1, empty: 1'b1, ovf: tok_ovf};
        norm_due_q.push_back(r);
      end
      for (int k = 0; k < tok_len; k++) begin
        r = '{ch: tok_chars[k], last: (k == tok_len - 1), empty: 1'b0, ovf: tok_ovf};
        norm_due_q.push_back(r);
      end
      tok_len = 0;
      tok_ovf = 1'b0;
    end
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // Result checker: one transfer per edge with valid high and stall low.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (norm_due_q.size() == 0) begin
        flag_error($sformatf("Unexpected result: char %h last %b empty %b ovf %b",
                             out_char_o, out_last_o, out_empty_o, out_overflow_o));
      end else begin
        due_head = norm_due_q.pop_front();
        if (out_last_o !== due_head.last || out_empty_o !== due_head.empty ||
            out_overflow_o !== due_head.ovf ||
            (!due_head.empty && out_char_o !== due_head.ch)) begin
          flag_error($sformatf(
              "Mismatch: expected char %h last %b empty %b ovf %b, got %h %b %b %b",
              due_head.ch, due_head.last, due_head.empty, due_head.ovf,
              out_char_o, out_last_o, out_empty_o, out_overflow_o));
        end
      end
    end
  end

  // Receiver stall pattern, with an occasional long hold-off on request.
  always @(posedge clk_i) begin
    rx_cycle++;
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      case (rx_mode)
        RX_RANDOM:   out_stall_i <= ($urandom_range(0, 99) < 40);
        RX_PERIODIC: out_stall_i <= ((rx_cycle % 9) >= 6);
        default:     out_stall_i <= 1'b0;
      endcase
    end
  end

  // Valid stays high from one transfer to the next unless a gap is inserted.
  task automatic send_char(input logic [CHAR_W-1:0] ch, input bit last);
    if (tx_bursty) begin
      if (burst_left == 0) begin
        gap_len    = $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
        in_valid_i <= 1'b0;
        repeat (gap_len) @(posedge clk_i);
      end
      burst_left--;
    end
    in_valid_i <= 1'b1;
    in_char_i  <= ch;
    in_last_i  <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    capture_char(ch, last);
  endtask

  task automatic send_token();
    for (int k = 0; k < stim_q.size(); k++) send_char(stim_q[k], k == stim_q.size() - 1);
  endtask

  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (norm_due_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [CHAR_W-1:0] rule_char(input int idx);
    case (idx)
      0:  return CH_CANDRABINDU;
      1:  return CH_II_SIGN;
      2:  return CH_UU_SIGN;
      3:  return CH_KA;
      4:  return CH_NGA;
      5:  return CH_YA;
      6:  return CH_BA;
      7:  return CH_VISARGA;
      8:  return CH_SHA;
      9:  return CH_SSA;
      10: return CH_NNA;
      11: return CH_RRA;
      12: return CH_RHA;
      13: return CH_KHANDA_TA;
      14: return CH_AA_SIGN;
      15: return CH_I_SIGN;
      default: return CH_VIRAMA;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return rule_char($urandom_range(0, 17));
    if (r < 80) return CHAR_W'(16'h0980 + $urandom_range(0, 127));
    if (r < 92) return CHAR_W'($urandom_range(0, 65535));
    return CHAR_W'($urandom_range(0, 127));
  endfunction

  // Random token built mostly from rule characters and virama clusters.
  task automatic build_token(input int len);
    stim_q.delete();
    while (stim_q.size() < len) begin
      if ($urandom_range(0, 99) < 30) begin
        case ($urandom_range(0, 4))
          0: begin stim_q.push_back(CH_KA); stim_q.push_back(CH_VIRAMA);
                   stim_q.push_back(CH_I_SIGN); end
          1: begin stim_q.push_back(CH_VIRAMA); stim_q.push_back(CH_YA); end
          2: begin stim_q.push_back(CH_VIRAMA); stim_q.push_back(CH_YA);
                   stim_q.push_back(CH_AA_SIGN); end
          3: begin stim_q.push_back(CH_VIRAMA); stim_q.push_back(CH_BA); end
          default: begin
            stim_q.push_back(CH_VIRAMA); stim_q.push_back(pick_char());
            stim_q.push_back(CH_VIRAMA); stim_q.push_back(CH_BA);
          end
        endcase
      end else begin
        stim_q.push_back(pick_char());
      end
    end
  endtask

  task automatic test_directed_rules();
    tx_bursty = 1'b1;
    rx_mode <= RX_RANDOM;
    send_char(16'h0000, 1'b0);
    send_char(16'hFFFF, 1'b1);
    // A lone chandrabindu leaves nothing: one empty result.
    send_char(CH_CANDRABINDU, 1'b1);
    // Khio at the start, then vowel-sign shortening.
    send_char(CH_KA, 1'b0);
    send_char(CH_VIRAMA, 1'b0);
    send_char(CH_I_SIGN, 1'b0);
    send_char(CH_II_SIGN, 1'b0);
    send_char(CH_UU_SIGN, 1'b1);
    // Ja-phala after the first letter with aa sign, nga, trailing visarga dropped.
    send_char(CH_KA, 1'b0);
    send_char(CH_VIRAMA, 1'b0);
    send_char(CH_YA, 1'b0);
    send_char(CH_AA_SIGN, 1'b0);
    send_char(CH_NGA, 1'b0);
    send_char(CH_VISARGA, 1'b1);
    // Ba-phala after the first letter, visarga doubling the next letter.
    send_char(CH_SHA, 1'b0);
    send_char(CH_VIRAMA, 1'b0);
    send_char(CH_BA, 1'b0);
    send_char(CH_VISARGA, 1'b0);
    send_char(CH_NNA, 1'b1);
    // Short token: final visarga becomes ha.
    send_char(CH_RRA, 1'b0);
    send_char(CH_VISARGA, 1'b1);
    // Khio not at the start, khanda-ta and the remaining folds.
    send_char(CH_KHANDA_TA, 1'b0);
    send_char(CH_KA, 1'b0);
    send_char(CH_VIRAMA, 1'b0);
    send_char(CH_I_SIGN, 1'b0);
    send_char(CH_SSA, 1'b0);
    send_char(CH_RHA, 1'b1);
  endtask

  task automatic test_overflow();
    tx_bursty = 1'b0;
    rx_mode <= RX_OPEN;
    // Exactly full: no overflow flag.
    for (int k = 0; k < TOKEN_DEPTH; k++) send_char(pick_char(), k == TOKEN_DEPTH - 1);
    // Everything deleted, last transfer dropped: empty result with overflow.
    for (int k = 0; k <= TOKEN_DEPTH; k++) send_char(CH_CANDRABINDU, k == TOKEN_DEPTH);
  endtask

  task automatic test_random_tokens();
    int kept;
    int r;
    kept = 0;
    while (kept < RANDOM_CHARS) begin
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 3))
        0:       rx_mode <= RX_OPEN;
        1:       rx_mode <= RX_PERIODIC;
        default: rx_mode <= RX_RANDOM;
      endcase
      tx_bursty = ($urandom_range(0, 3) != 0);
      if (r < 85) build_token($urandom_range(1, 8));
      else if (r < 96) build_token($urandom_range(9, 20));
      else build_token($urandom_range(30, 36));
      kept += (stim_q.size() < TOKEN_DEPTH) ? stim_q.size() : TOKEN_DEPTH;
      send_token();
    end
  endtask

  // Long receiver hold-off while tokens keep coming, so the input side stalls.
  task automatic test_output_backpressure();
    tx_bursty = 1'b0;
    rx_mode <= RX_OPEN;
    hold_requests <= hold_requests + 1;
    for (int n = 0; n < 3; n++) begin
      build_token($urandom_range(3, 8));
      send_token();
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_rules();
    test_overflow();
    test_output_backpressure();
    test_random_tokens();
    wait_results_drained();
    if (error_count == 0 && norm_due_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/bnorm_pkg.sv
src/bnorm_rules.sv
src/bnorm_dp.sv
src/bnorm_ctrl.sv
src/bengali_text_normalizer.sv
verif/testbench.sv
